@@ hw/rtl/stlr_pkg.sv @@
// ----------------------------------------------------------------------------
// stlr_pkg
// Shared types and constants for the linear speed ramp step-period generator.
// ----------------------------------------------------------------------------
package stlr_pkg;

    // motion phase of a move
    typedef enum logic [1:0] {
        PH_STOP  = 2'd0,
        PH_ACCEL = 2'd1,
        PH_RUN   = 2'd2,
        PH_DECEL = 2'd3
    } phase_t;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE   = 2'd0,
        ST_EVAL   = 2'd1,
        ST_DIVIDE = 2'd2,
        ST_FINISH = 2'd3
    } ctrl_state_t;

    // command codes
    localparam logic CMD_START = 1'b0;
    localparam logic CMD_TICK  = 1'b1;

    // configuration register indexes
    localparam int CFG_IDX_BITS = 3;
    localparam logic [CFG_IDX_BITS-1:0] REG_FIRST_DELAY    = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_CRUISE_DELAY   = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_BRAKE_STEP     = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_DECEL_COUNT    = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_SINGLE_STEP    = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_STOP_ON_SWITCH = 3'd5;

    localparam int PERIOD_BITS = 16;

    typedef struct packed {
        logic command;
        logic switch_hit;
    } in_item_t;

    typedef struct packed {
        logic [PERIOD_BITS-1:0] period;
        logic                   pulse_enable;
        logic                   running;
        logic                   done_res;
    } out_item_t;

    // sequencer to datapath
    typedef struct packed {
        logic load_item;
        logic eval;
        logic post;
        logic load_out;
    } dp_cmd_t;

    // datapath to sequencer
    typedef struct packed {
        logic need_div;
        logic div_busy;
        logic out_free;
    } dp_status_t;

endpackage

@@ hw/rtl/stlr_div.sv @@
// ----------------------------------------------------------------------------
// stlr_div
// Signed restoring divider, one quotient bit per cycle, truncating toward
// zero; the remainder takes the sign of the dividend.
// ----------------------------------------------------------------------------
module stlr_div
    import stlr_pkg::*;
#(
    parameter int W = 28
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic signed [W-1:0] num,
    input  logic signed [W-1:0] den,
    output logic                busy,
    output logic signed [W-1:0] quo,
    output logic signed [W-1:0] rem
);

    localparam int CNT_BITS = $clog2(W + 1);

    logic [CNT_BITS-1:0] count_reg, count_next;
    logic [W-1:0]        acc_reg, acc_next;    // dividend shifting out, quotient in
    logic [W-1:0]        part_reg, part_next;  // partial remainder
    logic [W-1:0]        dmag_reg, dmag_next;
    logic                neg_q_reg, neg_q_next;
    logic                neg_r_reg, neg_r_next;
    logic [W:0]          shifted;
    logic [W:0]          diff;

    always_comb
    begin
        count_next = count_reg;
        acc_next   = acc_reg;
        part_next  = part_reg;
        dmag_next  = dmag_reg;
        neg_q_next = neg_q_reg;
        neg_r_next = neg_r_reg;
        shifted    = {part_reg, acc_reg[W-1]};
        diff       = shifted - {1'b0, dmag_reg};
        if (start)
        begin
            count_next = CNT_BITS'(W);
            acc_next   = num[W-1] ? (W'(0) - W'(num)) : W'(num);
            dmag_next  = den[W-1] ? (W'(0) - W'(den)) : W'(den);
            part_next  = '0;
            neg_q_next = num[W-1] ^ den[W-1];
            neg_r_next = num[W-1];
        end
        else if (count_reg != '0)
        begin
            count_next = count_reg - CNT_BITS'(1);
            if (!diff[W])
            begin
                part_next = diff[W-1:0];
                acc_next  = {acc_reg[W-2:0], 1'b1};
            end
            else
            begin
                part_next = shifted[W-1:0];
                acc_next  = {acc_reg[W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg   <= acc_next;
        part_reg  <= part_next;
        dmag_reg  <= dmag_next;
        neg_q_reg <= neg_q_next;
        neg_r_reg <= neg_r_next;
    end

    assign busy = (count_reg != '0);
    assign quo  = neg_q_reg ? $signed(W'(0) - acc_reg) : $signed(acc_reg);
    assign rem  = neg_r_reg ? $signed(W'(0) - part_reg) : $signed(part_reg);

endmodule

@@ hw/rtl/stlr_dp.sv @@
// ----------------------------------------------------------------------------
// stlr_dp
// Datapath: configuration registers, ramp state, divider, result staging and
// output register.
// ----------------------------------------------------------------------------
module stlr_dp
    import stlr_pkg::*;
#(
    parameter int STEP_BITS  = 24,
    parameter int DELAY_BITS = 16,
    parameter int CFG_BITS   = 25
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  dp_cmd_t                 cmd,
    output dp_status_t              status,
    input  in_item_t                in_item,
    input  logic                    out_stall,
    output logic                    out_valid,
    output out_item_t               out_item,
    input  logic                    cfg_we,
    input  logic [CFG_IDX_BITS-1:0] cfg_index,
    input  logic [CFG_BITS-1:0]     cfg_data
);

    localparam int CBITS = STEP_BITS + 1;
    localparam int W     = ((DELAY_BITS > STEP_BITS) ? DELAY_BITS : STEP_BITS) + 4;
    localparam int PW    = (DELAY_BITS > PERIOD_BITS) ? DELAY_BITS : PERIOD_BITS;

    // configuration
    logic [DELAY_BITS-1:0]   first_delay_reg, cruise_delay_reg;
    logic [STEP_BITS-1:0]    brake_step_reg;
    logic signed [CBITS-1:0] decel_count_reg;
    logic                    single_step_reg, stop_on_switch_reg;

    // move state
    phase_t                  phase_reg, phase_next;
    logic [DELAY_BITS-1:0]   step_period_reg, step_period_next;
    logic signed [CBITS-1:0] ramp_count_reg, ramp_count_next;
    logic [STEP_BITS-1:0]    steps_done_reg, steps_done_next;
    logic signed [W-1:0]     remainder_reg, remainder_next;
    logic [DELAY_BITS-1:0]   last_ramp_reg, last_ramp_next;
    logic                    allowed_reg, allowed_next;

    // latched item and staged result
    in_item_t                item_reg;
    logic [DELAY_BITS-1:0]   res_period_reg, res_period_next;
    logic                    res_pulse_reg, res_pulse_next;
    logic                    res_running_reg, res_running_next;
    logic                    res_done_reg, res_done_next;

    logic                    out_valid_reg, out_valid_next;
    out_item_t               out_item_reg;

    logic                    allowed_tick;
    phase_t                  eff_phase;
    logic [STEP_BITS-1:0]    steps_inc;
    logic signed [CBITS-1:0] count_inc;
    logic signed [CBITS+1:0] den_short;
    logic signed [W-1:0]     div_num, div_den, quo, rem;
    logic                    div_start, div_busy;
    logic signed [W:0]       new_delay_wide;
    logic [DELAY_BITS-1:0]   new_delay;
    logic [PW-1:0]           period_wide;

    stlr_div #(.W(W)) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .busy  (div_busy),
        .quo   (quo),
        .rem   (rem)
    );

    always_comb
    begin
        allowed_tick = allowed_reg & ~(stop_on_switch_reg & item_reg.switch_hit);
        eff_phase    = allowed_tick ? phase_reg : PH_STOP;
        steps_inc    = steps_done_reg + STEP_BITS'(1);
        count_inc    = ramp_count_reg + CBITS'(1);
        den_short    = {count_inc, 2'b01};
        div_num      = $signed(W'({step_period_reg, 1'b0})) + remainder_reg;
        div_den      = W'(den_short);

        // clamp the new delay to the delay range
        new_delay_wide = $signed((W+1)'({1'b0, step_period_reg})) - (W+1)'(quo);
        if (new_delay_wide[W])
        begin
            new_delay = '0;
        end
        else if (new_delay_wide[W:DELAY_BITS] != '0)
        begin
            new_delay = '1;
        end
        else
        begin
            new_delay = new_delay_wide[DELAY_BITS-1:0];
        end
    end

    assign div_start = cmd.eval && item_reg.command == CMD_TICK
                       && (eff_phase == PH_ACCEL || eff_phase == PH_DECEL);

    always_comb
    begin
        phase_next       = phase_reg;
        step_period_next = step_period_reg;
        ramp_count_next  = ramp_count_reg;
        steps_done_next  = steps_done_reg;
        remainder_next   = remainder_reg;
        last_ramp_next   = last_ramp_reg;
        allowed_next     = allowed_reg;
        res_period_next  = res_period_reg;
        res_pulse_next   = res_pulse_reg;
        res_running_next = res_running_reg;
        res_done_next    = res_done_reg;

        if (cmd.eval)
        begin
            if (item_reg.command == CMD_START)
            begin
                allowed_next     = 1'b1;
                steps_done_next  = '0;
                remainder_next   = '0;
                step_period_next = first_delay_reg;
                if (single_step_reg)
                begin
                    ramp_count_next = '1;
                    phase_next      = PH_DECEL;
                end
                else
                begin
                    ramp_count_next = '0;
                    if (first_delay_reg <= cruise_delay_reg)
                    begin
                        step_period_next = cruise_delay_reg;
                        phase_next       = PH_RUN;
                    end
                    else
                    begin
                        phase_next = PH_ACCEL;
                    end
                end
                res_period_next  = '0;
                res_pulse_next   = 1'b0;
                res_running_next = 1'b1;
                res_done_next    = 1'b0;
            end
            else
            begin
                res_period_next = step_period_reg;
                res_done_next   = 1'b0;
                case (eff_phase)
                    PH_ACCEL, PH_DECEL:
                    begin
                        // finished in the post-divide update
                        steps_done_next = steps_inc;
                        ramp_count_next = count_inc;
                        allowed_next    = allowed_tick;
                    end
                    PH_RUN:
                    begin
                        steps_done_next  = steps_inc;
                        allowed_next     = allowed_tick;
                        step_period_next = cruise_delay_reg;
                        if (steps_inc >= brake_step_reg)
                        begin
                            ramp_count_next  = decel_count_reg;
                            step_period_next = last_ramp_reg;
                            phase_next       = PH_DECEL;
                        end
                        res_pulse_next   = 1'b1;
                        res_running_next = allowed_tick;
                    end
                    default:
                    begin
                        phase_next       = PH_STOP;
                        steps_done_next  = '0;
                        remainder_next   = '0;
                        allowed_next     = 1'b0;
                        res_pulse_next   = 1'b0;
                        res_running_next = 1'b0;
                        res_done_next    = allowed_reg;
                    end
                endcase
            end
        end
        else if (cmd.post)
        begin
            remainder_next   = rem;
            step_period_next = new_delay;
            res_pulse_next   = 1'b1;
            res_running_next = allowed_reg;
            if (phase_reg == PH_ACCEL)
            begin
                if (steps_done_reg >= brake_step_reg)
                begin
                    ramp_count_next = decel_count_reg;
                    phase_next      = PH_DECEL;
                end
                else if (new_delay <= cruise_delay_reg)
                begin
                    last_ramp_next   = new_delay;
                    step_period_next = cruise_delay_reg;
                    remainder_next   = '0;
                    phase_next       = PH_RUN;
                end
            end
            else if (!ramp_count_reg[CBITS-1])
            begin
                phase_next = PH_STOP;
            end
        end
    end

    assign out_valid_next = cmd.load_out | (out_valid_reg & out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_delay_reg    <= '1;
            cruise_delay_reg   <= DELAY_BITS'(1);
            brake_step_reg     <= '0;
            decel_count_reg    <= '1;
            single_step_reg    <= 1'b0;
            stop_on_switch_reg <= 1'b0;
            phase_reg          <= PH_STOP;
            step_period_reg    <= '0;
            ramp_count_reg     <= '0;
            steps_done_reg     <= '0;
            remainder_reg      <= '0;
            last_ramp_reg      <= '0;
            allowed_reg        <= 1'b0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_FIRST_DELAY:    first_delay_reg    <= cfg_data[DELAY_BITS-1:0];
                    REG_CRUISE_DELAY:   cruise_delay_reg   <= cfg_data[DELAY_BITS-1:0];
                    REG_BRAKE_STEP:     brake_step_reg     <= cfg_data[STEP_BITS-1:0];
                    REG_DECEL_COUNT:    decel_count_reg    <= $signed(cfg_data[CBITS-1:0]);
                    REG_SINGLE_STEP:    single_step_reg    <= cfg_data[0];
                    REG_STOP_ON_SWITCH: stop_on_switch_reg <= cfg_data[0];
                    default:            ;
                endcase
            end
            phase_reg       <= phase_next;
            step_period_reg <= step_period_next;
            ramp_count_reg  <= ramp_count_next;
            steps_done_reg  <= steps_done_next;
            remainder_reg   <= remainder_next;
            last_ramp_reg   <= last_ramp_next;
            allowed_reg     <= allowed_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            item_reg <= in_item;
        end
        res_period_reg  <= res_period_next;
        res_pulse_reg   <= res_pulse_next;
        res_running_reg <= res_running_next;
        res_done_reg    <= res_done_next;
        if (cmd.load_out)
        begin
            out_item_reg.period       <= period_wide[PERIOD_BITS-1:0];
            out_item_reg.pulse_enable <= res_pulse_reg;
            out_item_reg.running      <= res_running_reg;
            out_item_reg.done_res     <= res_done_reg;
        end
    end

    assign period_wide     = PW'(res_period_reg);
    assign status.need_div = div_start;
    assign status.div_busy = div_busy;
    assign status.out_free = ~out_valid_reg | ~out_stall;
    assign out_valid       = out_valid_reg;
    assign out_item        = out_item_reg;

endmodule

@@ hw/rtl/stlr_ctrl.sv @@
// ----------------------------------------------------------------------------
// stlr_ctrl
// Sequencer: takes a beat, evaluates it, waits out the divider when the
// ramp needs a new delay, then hands the result to the output register.
// ----------------------------------------------------------------------------
module stlr_ctrl
    import stlr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    output dp_cmd_t    cmd,
    input  dp_status_t status
);

    ctrl_state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                state_next = status.need_div ? ST_DIVIDE : ST_FINISH;
            end
            ST_DIVIDE:
            begin
                if (!status.div_busy)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_stall      = 1'b1;
        cmd.load_item = 1'b0;
        cmd.eval      = 1'b0;
        cmd.post      = 1'b0;
        cmd.load_out  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall      = 1'b0;
                cmd.load_item = in_valid;
            end
            ST_EVAL:
            begin
                cmd.eval = 1'b1;
            end
            ST_DIVIDE:
            begin
                cmd.post = ~status.div_busy;
            end
            ST_FINISH:
            begin
                cmd.load_out = status.out_free;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

@@ hw/rtl/stepper_linear_speed_ramp.sv @@
// path: a taken beat passes through the item register, the staged result and
// the output register; when the ramp recomputes the delay it also waits out
// the serial divider, which gives one quotient bit per cycle
// flow: one beat at a time; a new beat is taken only once the last result
// has gone to the output register
// reset: move stopped, delay and counters zero, registers at their defaults
// ----------------------------------------------------------------------------
// stepper_linear_speed_ramp
// Step-period generator with a linear acceleration and deceleration ramp.
// ----------------------------------------------------------------------------
module stepper_linear_speed_ramp
    import stlr_pkg::*;
#(
    parameter int STEP_BITS  = 24,
    parameter int DELAY_BITS = 16
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  in_item_t                in_item,
    output logic                    out_valid,
    input  logic                    out_stall,
    output out_item_t               out_item,
    input  logic                    cfg_we,
    input  logic [CFG_IDX_BITS-1:0] cfg_index,
    input  logic [((DELAY_BITS > STEP_BITS + 1) ? DELAY_BITS : STEP_BITS + 1)-1:0] cfg_data
);

    localparam int CFG_BITS = (DELAY_BITS > STEP_BITS + 1) ? DELAY_BITS : STEP_BITS + 1;

    dp_cmd_t    cmd;
    dp_status_t status;

    stlr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .cmd      (cmd),
        .status   (status)
    );

    stlr_dp #(
        .STEP_BITS  (STEP_BITS),
        .DELAY_BITS (DELAY_BITS),
        .CFG_BITS   (CFG_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .in_item   (in_item),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .out_item  (out_item),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

endmodule

@@ tb/tb_stepper_linear_speed_ramp.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_stepper_linear_speed_ramp
// Self-checking bench for the linear speed ramp step-period generator. A
// scoreboard predicts the step report for every accepted command and checks
// each returned report against it. Moves run under a range of profiles, with
// random handshake gaps on both sides and one long hold-off on the output.
// ----------------------------------------------------------------------------
module tb_stepper_linear_speed_ramp;
    import stlr_pkg::*;

    localparam int STEP_BITS     = 24;
    localparam int DELAY_BITS    = 16;
    localparam int CFG_BITS      = (DELAY_BITS > STEP_BITS + 1) ? DELAY_BITS : STEP_BITS + 1;
    localparam int SETTLE_CYCLES = STEP_BITS + 16;
    localparam int RANDOM_BEATS  = 950;
    localparam int HOLD_CYCLES   = 300;
    localparam int RUN_LIMIT     = 400000;
    localparam int MAX_MOVE      = 120;

    typedef struct packed {
        logic [DELAY_BITS-1:0] first_delay;
        logic [DELAY_BITS-1:0] cruise_delay;
        logic [STEP_BITS-1:0]  brake_step;
        logic [STEP_BITS:0]    decel_count;
        logic                  single_step;
        logic                  stop_on_switch;
    } move_profile_t;

    class ramp_scoreboard;
        logic [DELAY_BITS-1:0]    first_delay;
        logic [DELAY_BITS-1:0]    cruise_delay;
        logic [STEP_BITS-1:0]     brake_step;
        logic [STEP_BITS:0]       decel_count;
        logic                     single_step;
        logic                     stop_on_switch;

        phase_t                   motion;
        logic [DELAY_BITS-1:0]    step_period;
        logic [DELAY_BITS-1:0]    last_ramp_period;
        logic signed [STEP_BITS:0] ramp_count;
        logic [STEP_BITS-1:0]     steps_done;
        longint                   rest;
        logic                     output_allowed;

        out_item_t                expected_steps[$];
        int                       errors;

        function new();
            first_delay      = '1;
            cruise_delay     = DELAY_BITS'(1);
            brake_step       = '0;
            decel_count      = '1;
            single_step      = 1'b0;
            stop_on_switch   = 1'b0;
            motion           = PH_STOP;
            step_period      = '0;
            last_ramp_period = '0;
            ramp_count       = '0;
            steps_done       = '0;
            rest             = 0;
            output_allowed   = 1'b0;
            errors           = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_BITS-1:0] index, logic [CFG_BITS-1:0] data);
            case (index)
                REG_FIRST_DELAY:    first_delay    = data[DELAY_BITS-1:0];
                REG_CRUISE_DELAY:   cruise_delay   = data[DELAY_BITS-1:0];
                REG_BRAKE_STEP:     brake_step     = data[STEP_BITS-1:0];
                REG_DECEL_COUNT:    decel_count    = data[STEP_BITS:0];
                REG_SINGLE_STEP:    single_step    = data[0];
                REG_STOP_ON_SWITCH: stop_on_switch = data[0];
                default:
                begin
                end
            endcase
        endfunction

        // delay - (2*delay + rest) / (4*count + 1), truncating, clamped to the delay range
        function logic [DELAY_BITS-1:0] ramp_update();
            longint num;
            longint den;
            longint nd;
            num  = 2 * longint'(step_period) + rest;
            den  = 4 * longint'(ramp_count) + 1;
            nd   = longint'(step_period) - num / den;
            rest = num % den;
            if (nd < 0)
                return '0;
            if (nd >= (64'sd1 <<< DELAY_BITS))
                return '1;
            return nd[DELAY_BITS-1:0];
        endfunction

        function void note_command(in_item_t item);
            out_item_t             rep;
            logic                  was_active;
            logic [DELAY_BITS-1:0] next_period;
            rep = '0;
            if (item.command == CMD_START)
            begin
                output_allowed = 1'b1;
                steps_done     = '0;
                rest           = 0;
                step_period    = first_delay;
                if (single_step)
                begin
                    ramp_count = '1;
                    motion     = PH_DECEL;
                end
                else
                begin
                    ramp_count = '0;
                    if (first_delay <= cruise_delay)
                    begin
                        step_period = cruise_delay;
                        motion      = PH_RUN;
                    end
                    else
                        motion = PH_ACCEL;
                end
            end
            else
            begin
                was_active = output_allowed;
                if (stop_on_switch && item.switch_hit)
                    output_allowed = 1'b0;
                rep.period = step_period;
                if (!output_allowed)
                    motion = PH_STOP;
                next_period = step_period;
                case (motion)
                    PH_ACCEL:
                    begin
                        rep.pulse_enable = 1'b1;
                        steps_done       = steps_done + STEP_BITS'(1);
                        ramp_count       = ramp_count + (STEP_BITS + 1)'(1);
                        next_period      = ramp_update();
                        if (steps_done >= brake_step)
                        begin
                            ramp_count = decel_count;
                            motion     = PH_DECEL;
                        end
                        else if (next_period <= cruise_delay)
                        begin
                            last_ramp_period = next_period;
                            next_period      = cruise_delay;
                            rest             = 0;
                            motion           = PH_RUN;
                        end
                    end
                    PH_RUN:
                    begin
                        rep.pulse_enable = 1'b1;
                        steps_done       = steps_done + STEP_BITS'(1);
                        next_period      = cruise_delay;
                        if (steps_done >= brake_step)
                        begin
                            ramp_count  = decel_count;
                            next_period = last_ramp_period;
                            motion      = PH_DECEL;
                        end
                    end
                    PH_DECEL:
                    begin
                        rep.pulse_enable = 1'b1;
                        steps_done       = steps_done + STEP_BITS'(1);
                        ramp_count       = ramp_count + (STEP_BITS + 1)'(1);
                        next_period      = ramp_update();
                        if (ramp_count >= 0)
                            motion = PH_STOP;
                    end
                    default:
                    begin
                        steps_done     = '0;
                        rest           = 0;
                        output_allowed = 1'b0;
                        rep.done_res   = was_active;
                    end
                endcase
                step_period = next_period;
            end
            rep.running = output_allowed;
            expected_steps.push_back(rep);
        endfunction

        function void check_report(out_item_t got);
            out_item_t want;
            if (expected_steps.size() == 0)
            begin
                $error("step report with no command waiting: period %0d", got.period);
                errors++;
                return;
            end
            want = expected_steps.pop_front();
            if (got.period !== want.period)
            begin
                $error("period: expected %0d, got %0d", want.period, got.period);
                errors++;
            end
            if (got.pulse_enable !== want.pulse_enable)
            begin
                $error("pulse_enable: expected %0d, got %0d", want.pulse_enable,
                       got.pulse_enable);
                errors++;
            end
            if (got.running !== want.running)
            begin
                $error("running: expected %0d, got %0d", want.running, got.running);
                errors++;
            end
            if (got.done_res !== want.done_res)
            begin
                $error("done_res: expected %0d, got %0d", want.done_res, got.done_res);
                errors++;
            end
        endfunction
    endclass

    logic                    clk       = 1'b0;
    logic                    rst_n     = 1'b0;
    logic                    in_valid  = 1'b0;
    logic                    in_stall;
    in_item_t                in_item   = '0;
    logic                    out_valid;
    logic                    out_stall = 1'b0;
    out_item_t               out_item;
    logic                    cfg_we    = 1'b0;
    logic [CFG_IDX_BITS-1:0] cfg_index = '0;
    logic [CFG_BITS-1:0]     cfg_data  = '0;

    bit             calm         = 1'b0;
    bit             hold_request = 1'b0;
    int             hold_left    = 0;
    int             beats_sent   = 0;
    int             cycle_count  = 0;
    ramp_scoreboard ramp_sb;

    stepper_linear_speed_ramp #(
        .STEP_BITS (STEP_BITS),
        .DELAY_BITS(DELAY_BITS)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_item  (in_item),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_item (out_item),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    function automatic bit take_break();
        return !calm && ($urandom_range(99) < 27);
    endfunction

    // report side: random stalls, plus one long hold-off on request
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            ramp_sb.check_report(out_item);
        if (hold_request)
        begin
            hold_request = 1'b0;
            hold_left    = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
            out_stall <= take_break();
    end

    task automatic send_beat(logic command, logic switch_hit);
        in_item_t item;
        item.command    = command;
        item.switch_hit = switch_hit;
        while (take_break())
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= item;
        do
            @(posedge clk);
        while (in_stall);
        ramp_sb.note_command(item);
        beats_sent++;
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (ramp_sb.expected_steps.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic apply_config(move_profile_t p);
        logic [CFG_IDX_BITS-1:0] index [6];
        logic [CFG_BITS-1:0]     value [6];
        index = '{REG_FIRST_DELAY, REG_CRUISE_DELAY, REG_BRAKE_STEP, REG_DECEL_COUNT,
                  REG_SINGLE_STEP, REG_STOP_ON_SWITCH};
        value = '{CFG_BITS'(p.first_delay), CFG_BITS'(p.cruise_delay),
                  CFG_BITS'(p.brake_step), CFG_BITS'(p.decel_count),
                  CFG_BITS'(p.single_step), CFG_BITS'(p.stop_on_switch)};
        settle();
        for (int i = 0; i < 6; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= index[i];
            cfg_data  <= value[i];
            @(posedge clk);
            ramp_sb.write_reg(index[i], value[i]);
        end
        cfg_we <= 1'b0;
    endtask

    function automatic move_profile_t make_profile(longint fd, longint md, longint ds,
                                                   longint dc, bit ss, bit sos);
        move_profile_t p;
        p.first_delay    = fd[DELAY_BITS-1:0];
        p.cruise_delay   = md[DELAY_BITS-1:0];
        p.brake_step     = ds[STEP_BITS-1:0];
        p.decel_count    = dc[STEP_BITS:0];
        p.single_step    = ss;
        p.stop_on_switch = sos;
        return p;
    endfunction

    function automatic move_profile_t random_profile();
        move_profile_t p;
        int            pick;
        pick = $urandom_range(9);
        if (pick == 0)
            p.first_delay = '1;
        else if (pick == 1)
            p.first_delay = DELAY_BITS'(1);
        else
            p.first_delay = DELAY_BITS'($urandom_range(20000, 100));
        pick = $urandom_range(9);
        if (pick == 0)
            p.cruise_delay = '1;
        else if (pick == 1)
            p.cruise_delay = DELAY_BITS'($urandom_range(65535, 1));
        else
            p.cruise_delay = DELAY_BITS'(p.first_delay / $urandom_range(16, 2) + 1);
        if ($urandom_range(14) == 0)
            p.brake_step = '1;
        else
            p.brake_step = STEP_BITS'($urandom_range(40));
        if ($urandom_range(14) == 0)
            p.decel_count = {1'b1, {(STEP_BITS - 1){1'b0}}, 1'b1};
        else
            p.decel_count = (STEP_BITS + 1)'(0) - (STEP_BITS + 1)'($urandom_range(40, 1));
        p.single_step    = ($urandom_range(9) == 0);
        p.stop_on_switch = 1'($urandom_range(1));
        return p;
    endfunction

    // one start followed by roughly enough ticks to finish the move
    task automatic run_move(move_profile_t p);
        longint len;
        int     span;
        int     ticks;
        len = -longint'($signed(p.decel_count)) + 4;
        if (!p.single_step)
            len += p.brake_step;
        if (len < 1)
            len = 1;
        span  = (len > MAX_MOVE) ? MAX_MOVE : int'(len);
        ticks = ($urandom_range(9) == 0) ? $urandom_range(span, 1)
                                         : span + $urandom_range(2);
        send_beat(CMD_START, 1'($urandom_range(1)));
        repeat (ticks)
        begin
            // stray commands, including restarts in the middle of a move
            if ($urandom_range(99) < 4)
                send_beat(1'($urandom_range(1)), 1'($urandom_range(1)));
            else
                send_beat(CMD_TICK, $urandom_range(99) < 3);
        end
    endtask

    initial
    begin
        wait (cycle_count >= RUN_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        move_profile_t p;
        int            random_target;
        int            phase_no;
        ramp_sb = new();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // registers at reset: tick with no move, then a move that brakes on its first step and ends on its second
        send_beat(CMD_TICK, 1'b1);
        send_beat(CMD_START, 1'b0);
        repeat (3) send_beat(CMD_TICK, 1'b0);

        // first delay already at full speed, far deceleration, switch aborts
        apply_config(make_profile(1, 65535, 16777215, -16777215, 1'b0, 1'b1));
        send_beat(CMD_START, 1'b1);
        repeat (2) send_beat(CMD_TICK, 1'b0);
        send_beat(CMD_START, 1'b0);
        send_beat(CMD_TICK, 1'b0);
        send_beat(CMD_TICK, 1'b1);
        send_beat(CMD_TICK, 1'b1);

        // deceleration overshoots the delay range, then clamps at zero
        apply_config(make_profile(60000, 1, 0, -3, 1'b0, 1'b0));
        send_beat(CMD_START, 1'b0);
        repeat (5) send_beat(CMD_TICK, 1'b1);

        // single step move
        apply_config(make_profile(65535, 65535, 0, -1, 1'b1, 1'b1));
        send_beat(CMD_START, 1'b0);
        repeat (2) send_beat(CMD_TICK, 1'b0);

        // non-negative deceleration count ends the move on its first decel step
        apply_config(make_profile(1000, 10, 2, 3, 1'b0, 1'b0));
        send_beat(CMD_START, 1'b0);
        repeat (4) send_beat(CMD_TICK, 1'b0);

        random_target = beats_sent + RANDOM_BEATS;
        phase_no      = 0;
        while (beats_sent < random_target)
        begin
            p = random_profile();
            apply_config(p);
            calm = (phase_no == 1);
            if (phase_no == 0)
                hold_request = 1'b1;
            repeat ($urandom_range(3, 1)) run_move(p);
            phase_no++;
        end
        calm = 1'b0;
        settle();

        if (ramp_sb.errors == 0 && ramp_sb.expected_steps.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
